FILE: sv/svge_pkg.sv
// Shared types, constants and codes of the state-vector gate engine.
`timescale 1ns / 1ps
package svge_pkg;

  localparam int MAX_QUBITS_DEF = 10;
  localparam int AMP_BITS_DEF   = 16;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 10;
  localparam int LOAD_W   = 16;
  localparam int QUBIT_W  = 4;
  localparam int READ_W   = 16;
  localparam int STATUS_W = 2;
  localparam int QCOUNT_W = 4;

  localparam logic [QCOUNT_W-1:0] QUBIT_COUNT_RESET = 4'd10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_CNOT  = 2'd1,
    OP_ZFLIP = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_QUBIT = 2'd1,
    ST_BAD_ADDR  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RD_DATA,
    S_Z_RD,
    S_Z_WR,
    S_CX_RD_I,
    S_CX_RD_J,
    S_CX_WR_I,
    S_CX_WR_J,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [INDEX_W-1:0]       basis_index;
    logic signed [LOAD_W-1:0] load_real;
    logic signed [LOAD_W-1:0] load_imag;
    logic [QUBIT_W-1:0]       target_qubit;
    logic [QUBIT_W-1:0]       control_qubit;
  } req_t;

  typedef struct packed {
    logic signed [READ_W-1:0] read_real;
    logic signed [READ_W-1:0] read_imag;
    logic [STATUS_W-1:0]      status;
  } rsp_t;

endpackage

FILE: sv/svge_if.sv
// Request, response and configuration channel interfaces of the gate engine.
`timescale 1ns / 1ps
interface svge_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [svge_pkg::OPCODE_W-1:0]        opcode;
  logic [svge_pkg::INDEX_W-1:0]         basis_index;
  logic signed [svge_pkg::LOAD_W-1:0]   load_real;
  logic signed [svge_pkg::LOAD_W-1:0]   load_imag;
  logic [svge_pkg::QUBIT_W-1:0]         target_qubit;
  logic [svge_pkg::QUBIT_W-1:0]         control_qubit;

  modport source (output valid, opcode, basis_index, load_real, load_imag, target_qubit,
                  control_qubit, input ready);
  modport sink (input valid, opcode, basis_index, load_real, load_imag, target_qubit,
                control_qubit, output ready);
endinterface

interface svge_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [svge_pkg::READ_W-1:0]   read_real;
  logic signed [svge_pkg::READ_W-1:0]   read_imag;
  logic [svge_pkg::STATUS_W-1:0]        status;

  modport source (output valid, read_real, read_imag, status, input ready);
  modport sink (input valid, read_real, read_imag, status, output ready);
endinterface

interface svge_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [svge_pkg::QCOUNT_W-1:0]        qubit_count;

  modport source (output valid, qubit_count, input ready);
  modport sink (input valid, qubit_count, output ready);
endinterface

FILE: sv/svge_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module svge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/state_vector_gate_engine.sv
// Top level of the state-vector gate engine: control sequencer and amplitude datapath.
//
//   Channel  Direction  Contents
//   req_i    in         opcode, basis_index, load_real, load_imag, target_qubit, control_qubit
//   rsp_o    out        read_real, read_imag, status
//   cfg_i    in         qubit_count
//
// One request is in work at a time; the amplitude RAM has one read and one write port.
// Phase flip and CNOT step through all S = 2^n amplitudes in turn, set by the RAM ports.
// Reset clears control state only; amplitudes are undefined until loaded.
// A result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
module state_vector_gate_engine #(
  parameter int MAX_QUBITS = svge_pkg::MAX_QUBITS_DEF,
  parameter int AMP_BITS   = svge_pkg::AMP_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  svge_req_if.sink    req_i,
  svge_rsp_if.source  rsp_o,
  svge_cfg_if.sink    cfg_i
);

  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 1 << MAX_QUBITS;
  localparam int NW0   = $clog2(MAX_QUBITS + 1);
  localparam int QW    = (NW0 > svge_pkg::QUBIT_W) ? NW0 : svge_pkg::QUBIT_W;
  localparam int WW    = 2 * AMP_BITS;

  localparam logic signed [33:0] AMP_MAX = (34'sd1 <<< (AMP_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] AMP_MIN = -AMP_MAX - 34'sd1;
  localparam logic signed [33:0] RD_MAX  = 34'sd32767;
  localparam logic signed [33:0] RD_MIN  = -34'sd32768;

  function automatic logic [AMP_BITS-1:0] sat_amp(input logic signed [33:0] v);
    logic [AMP_BITS-1:0] r;
    if (v > AMP_MAX) begin
      r = AMP_MAX[AMP_BITS-1:0];
    end else if (v < AMP_MIN) begin
      r = AMP_MIN[AMP_BITS-1:0];
    end else begin
      r = v[AMP_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [svge_pkg::READ_W-1:0] sat_rd(input logic signed [33:0] v);
    logic [svge_pkg::READ_W-1:0] r;
    if (v > RD_MAX) begin
      r = RD_MAX[svge_pkg::READ_W-1:0];
    end else if (v < RD_MIN) begin
      r = RD_MIN[svge_pkg::READ_W-1:0];
    end else begin
      r = v[svge_pkg::READ_W-1:0];
    end
    return r;
  endfunction

  svge_pkg::state_e state_q, state_d;
  svge_pkg::req_t   req_q;
  svge_pkg::rsp_t   res_q, res_d, rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic [svge_pkg::QCOUNT_W-1:0] qcount_q;
  logic [AW-1:0]    idx_q, idx_d;
  logic [WW-1:0]    hold_q, hold_d;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [WW-1:0]    mem_wdata, mem_rdata;

  logic [QW-1:0]    qcount_ext, n_act;
  logic [AW-1:0]    size_mask, tmask, cmask, partner;
  logic             addr_bad, cnot_bad, z_bad, idx_last, z_hit, cx_hit, req_fire, rsp_free;
  logic signed [AMP_BITS-1:0] rd_re, rd_im, hd_re, hd_im;

  svge_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_amp_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign req_i.ready = (state_q == svge_pkg::S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_real = rsp_q.read_real;
  assign rsp_o.read_imag = rsp_q.read_imag;
  assign rsp_o.status    = rsp_q.status;

  always_comb begin
    qcount_ext = QW'(qcount_q);
    if (qcount_ext == '0) begin
      n_act = QW'(1);
    end else if (qcount_ext > QW'(MAX_QUBITS)) begin
      n_act = QW'(MAX_QUBITS);
    end else begin
      n_act = qcount_ext;
    end
  end

  assign size_mask = {AW{1'b1}} >> (QW'(AW) - n_act);
  assign tmask     = AW'(1) << req_q.target_qubit;
  assign cmask     = AW'(1) << req_q.control_qubit;
  assign partner   = idx_q | tmask;
  assign addr_bad  = (req_q.basis_index >> n_act) != '0;
  assign z_bad     = QW'(req_q.target_qubit) >= n_act;
  assign cnot_bad  = z_bad || (QW'(req_q.control_qubit) >= n_act) ||
                     (req_q.target_qubit == req_q.control_qubit);
  assign idx_last  = (idx_q == size_mask);
  assign z_hit     = |(idx_q & tmask);
  assign cx_hit    = (|(idx_q & cmask)) && !z_hit;

  assign rd_re = mem_rdata[WW-1:AMP_BITS];
  assign rd_im = mem_rdata[AMP_BITS-1:0];
  assign hd_re = hold_q[WW-1:AMP_BITS];
  assign hd_im = hold_q[AMP_BITS-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      svge_pkg::S_IDLE: begin
        if (req_fire) begin
          state_d = svge_pkg::S_EXEC;
        end
      end
      svge_pkg::S_EXEC: begin
        case (svge_pkg::opcode_e'(req_q.opcode))
          svge_pkg::OP_READ:  state_d = addr_bad ? svge_pkg::S_DONE : svge_pkg::S_RD_DATA;
          svge_pkg::OP_CNOT:  state_d = cnot_bad ? svge_pkg::S_DONE : svge_pkg::S_CX_RD_I;
          svge_pkg::OP_ZFLIP: state_d = z_bad ? svge_pkg::S_DONE : svge_pkg::S_Z_RD;
          default:            state_d = svge_pkg::S_DONE;
        endcase
      end
      svge_pkg::S_RD_DATA: state_d = svge_pkg::S_DONE;
      svge_pkg::S_Z_RD: begin
        if (z_hit) begin
          state_d = svge_pkg::S_Z_WR;
        end else if (idx_last) begin
          state_d = svge_pkg::S_DONE;
        end
      end
      svge_pkg::S_Z_WR: state_d = idx_last ? svge_pkg::S_DONE : svge_pkg::S_Z_RD;
      svge_pkg::S_CX_RD_I: begin
        if (cx_hit) begin
          state_d = svge_pkg::S_CX_RD_J;
        end else if (idx_last) begin
          state_d = svge_pkg::S_DONE;
        end
      end
      svge_pkg::S_CX_RD_J: state_d = svge_pkg::S_CX_WR_I;
      svge_pkg::S_CX_WR_I: state_d = svge_pkg::S_CX_WR_J;
      svge_pkg::S_CX_WR_J: state_d = idx_last ? svge_pkg::S_DONE : svge_pkg::S_CX_RD_I;
      svge_pkg::S_DONE: begin
        if (rsp_free) begin
          state_d = svge_pkg::S_IDLE;
        end
      end
      default: state_d = svge_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_q;
    mem_raddr   = idx_q;
    mem_wdata   = '0;
    idx_d       = idx_q;
    hold_d      = hold_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    case (state_q)
      svge_pkg::S_IDLE: begin
        res_d = '0;
      end
      svge_pkg::S_EXEC: begin
        idx_d = '0;
        case (svge_pkg::opcode_e'(req_q.opcode))
          svge_pkg::OP_LOAD: begin
            if (addr_bad) begin
              res_d.status = svge_pkg::ST_BAD_ADDR;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(req_q.basis_index);
              mem_wdata = {sat_amp(34'(signed'(req_q.load_real))),
                           sat_amp(34'(signed'(req_q.load_imag)))};
            end
          end
          svge_pkg::OP_READ: begin
            if (addr_bad) begin
              res_d.status = svge_pkg::ST_BAD_ADDR;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(req_q.basis_index);
            end
          end
          svge_pkg::OP_CNOT: begin
            if (cnot_bad) begin
              res_d.status = svge_pkg::ST_BAD_QUBIT;
            end
          end
          default: begin
            if (z_bad) begin
              res_d.status = svge_pkg::ST_BAD_QUBIT;
            end
          end
        endcase
      end
      svge_pkg::S_RD_DATA: begin
        res_d.read_real = sat_rd(34'(rd_re));
        res_d.read_imag = sat_rd(34'(rd_im));
      end
      svge_pkg::S_Z_RD: begin
        if (z_hit) begin
          mem_re = 1'b1;
        end else if (!idx_last) begin
          idx_d = idx_q + AW'(1);
        end
      end
      svge_pkg::S_Z_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {sat_amp(-34'(rd_re)), sat_amp(-34'(rd_im))};
        if (!idx_last) begin
          idx_d = idx_q + AW'(1);
        end
      end
      svge_pkg::S_CX_RD_I: begin
        if (cx_hit) begin
          mem_re = 1'b1;
        end else if (!idx_last) begin
          idx_d = idx_q + AW'(1);
        end
      end
      svge_pkg::S_CX_RD_J: begin
        mem_re    = 1'b1;
        mem_raddr = partner;
        hold_d    = mem_rdata;
      end
      svge_pkg::S_CX_WR_I: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      svge_pkg::S_CX_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = partner;
        mem_wdata = {hd_re, hd_im};
        if (!idx_last) begin
          idx_d = idx_q + AW'(1);
        end
      end
      svge_pkg::S_DONE: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_d       = res_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svge_pkg::S_IDLE;
      rsp_valid_q <= 1'b0;
      qcount_q    <= svge_pkg::QUBIT_COUNT_RESET;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        qcount_q <= cfg_i.qubit_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q.opcode        <= req_i.opcode;
      req_q.basis_index   <= req_i.basis_index;
      req_q.load_real     <= req_i.load_real;
      req_q.load_imag     <= req_i.load_imag;
      req_q.target_qubit  <= req_i.target_qubit;
      req_q.control_qubit <= req_i.control_qubit;
    end
    idx_q  <= idx_d;
    hold_q <= hold_d;
    res_q  <= res_d;
    rsp_q  <= rsp_d;
  end

endmodule

FILE: sv/svge_checker.sv
// Port-level assertions of the gate engine and the bind that attaches them.
`timescale 1ns / 1ps
module svge_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid_i,
  input logic                                req_ready_i,
  input logic                                rsp_valid_i,
  input logic                                rsp_ready_i,
  input logic signed [svge_pkg::READ_W-1:0]  rsp_read_real_i,
  input logic signed [svge_pkg::READ_W-1:0]  rsp_read_imag_i,
  input logic [svge_pkg::STATUS_W-1:0]       rsp_status_i
);

  // A response is held until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
    $stable(rsp_read_real_i) && $stable(rsp_read_imag_i))
    else $error("response changed while stalled");

  // Only one request is in work, so no request is taken right after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // A failed request returns zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != svge_pkg::ST_OK) |->
    (rsp_read_real_i == '0) && (rsp_read_imag_i == '0))
    else $error("nonzero data with error status");

  // Every response has a defined status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == svge_pkg::ST_OK) ||
    (rsp_status_i == svge_pkg::ST_BAD_QUBIT) || (rsp_status_i == svge_pkg::ST_BAD_ADDR))
    else $error("undefined response status");

endmodule

bind state_vector_gate_engine svge_checker u_svge_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_read_real_i(rsp_o.read_real),
  .rsp_read_imag_i(rsp_o.read_imag),
  .rsp_status_i   (rsp_o.status)
);

FILE: test/state_vector_gate_engine_tb.sv
// Self-checking testbench for the state-vector gate engine, with a behavioral state model.
`timescale 1ns / 1ps
module state_vector_gate_engine_tb;

  localparam int CLK_HALF_NS = 6;
  localparam int RESET_CYCLES = 8;
  localparam int LOAD_W = svge_pkg::LOAD_W;
  localparam int INDEX_W = svge_pkg::INDEX_W;
  localparam int QUBIT_W = svge_pkg::QUBIT_W;
  localparam int QCOUNT_W = svge_pkg::QCOUNT_W;
  localparam int STATE_DEPTH = 1 << svge_pkg::MAX_QUBITS_DEF;
  localparam int PRIME_LOADS = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic signed [LOAD_W-1:0] AMP_MAX = 16'sh7fff;
  localparam logic signed [LOAD_W-1:0] AMP_MIN = 16'sh8000;

  typedef struct {
    svge_pkg::req_t request;
    svge_pkg::rsp_t response;
  } gate_job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  svge_req_if req_ch();
  svge_rsp_if rsp_ch();
  svge_cfg_if cfg_ch();

  state_vector_gate_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  logic signed [LOAD_W-1:0] shadow_re [STATE_DEPTH];
  logic signed [LOAD_W-1:0] shadow_im [STATE_DEPTH];
  bit shadow_loaded [STATE_DEPTH];
  logic [QCOUNT_W-1:0] shadow_qcount = svge_pkg::QUBIT_COUNT_RESET;

  gate_job_t request_backlog [$];
  svge_pkg::rsp_t expected_results [$];
  gate_job_t backlog_head;
  svge_pkg::rsp_t in_flight_result;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int mismatch_count = 0;
  longint cycle_count = 0;

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  function automatic int active_qubits();
    if (shadow_qcount < 1) return 1;
    if (shadow_qcount > svge_pkg::MAX_QUBITS_DEF) return svge_pkg::MAX_QUBITS_DEF;
    return int'(shadow_qcount);
  endfunction

  function automatic logic signed [LOAD_W-1:0] negate_saturated(logic signed [LOAD_W-1:0] v);
    return (v == AMP_MIN) ? AMP_MAX : -v;
  endfunction

  function automatic svge_pkg::rsp_t apply_gate_request(svge_pkg::req_t rq);
    svge_pkg::rsp_t rs;
    int n;
    int size;
    int j;
    int cmask;
    int tmask;
    logic signed [LOAD_W-1:0] keep_re;
    logic signed [LOAD_W-1:0] keep_im;
    bit keep_loaded;
    rs = '0;
    n = active_qubits();
    size = 1 << n;
    cmask = 1 << rq.control_qubit;
    tmask = 1 << rq.target_qubit;
    case (svge_pkg::opcode_e'(rq.opcode))
      svge_pkg::OP_LOAD, svge_pkg::OP_READ: begin
        if (rq.basis_index >= size) begin
          rs.status = svge_pkg::ST_BAD_ADDR;
        end else if (rq.opcode == svge_pkg::OP_LOAD) begin
          shadow_re[rq.basis_index] = rq.load_real;
          shadow_im[rq.basis_index] = rq.load_imag;
          shadow_loaded[rq.basis_index] = 1'b1;
        end else begin
          rs.read_real = shadow_re[rq.basis_index];
          rs.read_imag = shadow_im[rq.basis_index];
        end
      end
      svge_pkg::OP_CNOT: begin
        if (rq.target_qubit >= n || rq.control_qubit >= n ||
            rq.target_qubit == rq.control_qubit) begin
          rs.status = svge_pkg::ST_BAD_QUBIT;
        end else begin
          for (int i = 0; i < size; i++) begin
            if ((i & cmask) != 0 && (i & tmask) == 0) begin
              j = i | tmask;
              keep_re = shadow_re[i];
              keep_im = shadow_im[i];
              keep_loaded = shadow_loaded[i];
              shadow_re[i] = shadow_re[j];
              shadow_im[i] = shadow_im[j];
              shadow_loaded[i] = shadow_loaded[j];
              shadow_re[j] = keep_re;
              shadow_im[j] = keep_im;
              shadow_loaded[j] = keep_loaded;
            end
          end
        end
      end
      default: begin
        if (rq.target_qubit >= n) begin
          rs.status = svge_pkg::ST_BAD_QUBIT;
        end else begin
          for (int i = 0; i < size; i++) begin
            if ((i & tmask) != 0) begin
              shadow_re[i] = negate_saturated(shadow_re[i]);
              shadow_im[i] = negate_saturated(shadow_im[i]);
            end
          end
        end
      end
    endcase
    return rs;
  endfunction

  function automatic svge_pkg::req_t make_request(svge_pkg::opcode_e op,
                                                  logic [INDEX_W-1:0] addr,
                                                  logic signed [LOAD_W-1:0] re,
                                                  logic signed [LOAD_W-1:0] im,
                                                  logic [QUBIT_W-1:0] tq,
                                                  logic [QUBIT_W-1:0] cq);
    svge_pkg::req_t rq;
    rq.opcode = op;
    rq.basis_index = addr;
    rq.load_real = re;
    rq.load_imag = im;
    rq.target_qubit = tq;
    rq.control_qubit = cq;
    return rq;
  endfunction

  // Reads in range only ever target amplitudes that hold a loaded value.
  function automatic svge_pkg::req_t random_request();
    svge_pkg::req_t rq;
    logic [63:0] raw;
    int n;
    int size;
    int pick;
    int loaded_addrs [$];
    raw = {$urandom, $urandom};
    rq = raw[$bits(svge_pkg::req_t)-1:0];
    n = active_qubits();
    size = 1 << n;
    if ($urandom_range(99) < 12) rq.load_real = $urandom_range(1) ? AMP_MAX : AMP_MIN;
    if ($urandom_range(99) < 12) rq.load_imag = $urandom_range(1) ? AMP_MAX : AMP_MIN;
    pick = $urandom_range(99);
    if (pick < 25) begin
      rq.opcode = svge_pkg::OP_LOAD;
      if ($urandom_range(99) < 88) rq.basis_index = INDEX_W'($urandom_range(size - 1));
    end else if (pick < 55) begin
      rq.opcode = svge_pkg::OP_READ;
      for (int a = 0; a < size; a++) begin
        if (shadow_loaded[a]) loaded_addrs.push_back(a);
      end
      if (size < STATE_DEPTH && $urandom_range(99) < 15) begin
        rq.basis_index = INDEX_W'($urandom_range(STATE_DEPTH - 1, size));
      end else if (loaded_addrs.size() != 0) begin
        rq.basis_index = INDEX_W'(loaded_addrs[$urandom_range(loaded_addrs.size() - 1)]);
      end else begin
        rq.opcode = svge_pkg::OP_LOAD;
        rq.basis_index = INDEX_W'($urandom_range(size - 1));
      end
    end else if (pick < 78) begin
      rq.opcode = svge_pkg::OP_CNOT;
      if (n > 1 && $urandom_range(99) < 85) begin
        rq.target_qubit = QUBIT_W'($urandom_range(n - 1));
        rq.control_qubit = QUBIT_W'((rq.target_qubit + $urandom_range(n - 1, 1)) % n);
      end
    end else begin
      rq.opcode = svge_pkg::OP_ZFLIP;
      if ($urandom_range(99) < 85) rq.target_qubit = QUBIT_W'($urandom_range(n - 1));
    end
    return rq;
  endfunction

  task automatic queue_request(svge_pkg::req_t rq);
    gate_job_t job;
    job.request = rq;
    job.response = apply_gate_request(rq);
    request_backlog.push_back(job);
  endtask

  task automatic queue_random(int count);
    repeat (count) queue_request(random_request());
  endtask

  // Small states are loaded whole; larger ones get a scattered set of loads.
  task automatic prime_state();
    int size;
    size = 1 << active_qubits();
    for (int a = 0; a < size && a < PRIME_LOADS; a++) begin
      queue_request(make_request(svge_pkg::OP_LOAD,
                                 INDEX_W'((size <= PRIME_LOADS) ? a : $urandom_range(size - 1)),
                                 LOAD_W'($urandom), LOAD_W'($urandom),
                                 QUBIT_W'($urandom), QUBIT_W'($urandom)));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_backlog.size() != 0 || req_ch.valid || expected_results.size() != 0);
  endtask

  task automatic write_qubit_count(logic [QCOUNT_W-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.qubit_count <= value;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_qcount = value;
  endtask

  task automatic check_result(svge_pkg::rsp_t got);
    svge_pkg::rsp_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("ERROR: unexpected result real %0d imag %0d status %0d",
                 got.read_real, got.read_imag, got.status);
    end else begin
      want = expected_results.pop_front();
      if (got.read_real !== want.read_real || got.read_imag !== want.read_imag ||
          got.status !== want.status) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("ERROR: expected real %0d imag %0d status %0d, got real %0d imag %0d status %0d",
                   want.read_real, want.read_imag, want.status,
                   got.read_real, got.read_imag, got.status);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) expected_results.push_back(in_flight_result);
      if (!req_ch.valid || req_ch.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          backlog_head = request_backlog.pop_front();
          in_flight_result = backlog_head.response;
          req_ch.valid <= 1'b1;
          req_ch.opcode <= backlog_head.request.opcode;
          req_ch.basis_index <= backlog_head.request.basis_index;
          req_ch.load_real <= backlog_head.request.load_real;
          req_ch.load_imag <= backlog_head.request.load_imag;
          req_ch.target_qubit <= backlog_head.request.target_qubit;
          req_ch.control_qubit <= backlog_head.request.control_qubit;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        check_result({rsp_ch.read_real, rsp_ch.read_imag, rsp_ch.status});
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.opcode = svge_pkg::OP_LOAD;
    req_ch.basis_index = '0;
    req_ch.load_real = '0;
    req_ch.load_imag = '0;
    req_ch.target_qubit = '0;
    req_ch.control_qubit = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.qubit_count = svge_pkg::QUBIT_COUNT_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes, double negation of the most negative value, swaps and rejected gates.
    queue_request(make_request(svge_pkg::OP_LOAD, 10'd0, AMP_MAX, AMP_MIN, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_LOAD, 10'd1023, AMP_MIN, AMP_MAX, 4'd15, 4'd15));
    queue_request(make_request(svge_pkg::OP_LOAD, 10'd512, -16'sd1, 16'sd1, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_LOAD, 10'd1, 16'sd0, AMP_MIN, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_READ, 10'd0, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_READ, 10'd1023, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_ZFLIP, 10'd0, 16'sd0, 16'sd0, 4'd9, 4'd15));
    queue_request(make_request(svge_pkg::OP_READ, 10'd1023, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_READ, 10'd512, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_ZFLIP, 10'd0, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_READ, 10'd1, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_CNOT, 10'd0, 16'sd0, 16'sd0, 4'd0, 4'd9));
    queue_request(make_request(svge_pkg::OP_READ, 10'd513, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_READ, 10'd1022, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_CNOT, 10'd0, 16'sd0, 16'sd0, 4'd3, 4'd3));
    queue_request(make_request(svge_pkg::OP_CNOT, 10'd0, 16'sd0, 16'sd0, 4'd10, 4'd0));
    queue_request(make_request(svge_pkg::OP_CNOT, 10'd0, 16'sd0, 16'sd0, 4'd0, 4'd15));
    queue_request(make_request(svge_pkg::OP_ZFLIP, 10'd0, 16'sd0, 16'sd0, 4'd10, 4'd0));
    queue_request(make_request(svge_pkg::OP_ZFLIP, 10'd0, 16'sd0, 16'sd0, 4'd15, 4'd0));
    queue_request(make_request(svge_pkg::OP_READ, 10'd0, 16'sd0, 16'sd0, 4'd0, 4'd0));
    wait_idle();

    write_qubit_count(4'd3);
    queue_request(make_request(svge_pkg::OP_READ, 10'd8, 16'sd0, 16'sd0, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_LOAD, 10'd1023, AMP_MAX, AMP_MAX, 4'd0, 4'd0));
    queue_request(make_request(svge_pkg::OP_READ, 10'd1023, 16'sd0, 16'sd0, 4'd0, 4'd0));
    prime_state();
    queue_random(25);
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    wait_idle();
    queue_random(15);
    wait_idle();

    write_qubit_count(4'd1);
    send_idle_pct = 84;
    prime_state();
    queue_random(35);
    wait_idle();

    write_qubit_count(4'd0);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    prime_state();
    queue_random(30);
    wait_idle();

    write_qubit_count(4'd15);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    prime_state();
    queue_random(30);
    wait_idle();

    write_qubit_count(4'd5);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    prime_state();
    queue_random(25);
    wait_idle();

    write_qubit_count(4'd2);
    send_idle_pct = 84;
    prime_state();
    queue_random(25);
    wait_idle();

    write_qubit_count(4'd10);
    send_idle_pct = 20;
    recv_stall_pct = 84;
    queue_random(15);
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
